### src/pjms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjms_pkg
// Types and constants shared by the per-joint motion statistics block.
// ----------------------------------------------------------------------------
package pjms_pkg;

  localparam int COORD_W = 20;
  localparam int SUM_W   = 40;
  localparam int COUNT_W = 32;
  localparam int FRAME_W = 32;
  localparam int SLOT_W  = 7;
  localparam int AXES    = 3;

  localparam logic [FRAME_W-1:0] START_FRAME_RESET = 32'd15;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SUM_W-1:0]          sum_t;
  typedef logic [COUNT_W-1:0]        count_t;

  // One memory row holds everything known about a joint.
  typedef struct packed {
    coord_t [AXES-1:0] low;
    coord_t [AXES-1:0] high;
    coord_t [AXES-1:0] last;
    sum_t   [AXES-1:0] travel;
    count_t            count;
  } joint_stats_t;

endpackage

### src/per_joint_motion_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_joint_motion_stats
// Per-joint running minimum, maximum, travel sums and sample count.
// ----------------------------------------------------------------------------
// A position request arrives on in_valid/in_stall with its joint slot, frame
// number and x/y/z position. Every request produces exactly one result request
// on out_valid/out_stall. A request whose frame is below start_frame, or whose
// slot is not below NUM_JOINTS, returns accepted = 0 with all statistics
// zero and changes nothing.
// start_frame is written through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce.
// A joint's row is read from memory into rd_row when a request is accepted,
// then updated, written back and loaded into the result register once that
// register is free. One request is taken every cycle while in_stall is low;
// a write-back register forwards the last update to a following request for
// the same joint. When the receiver stalls, the result register holds and
// one more request can sit in the update stage; after that in_stall rises.
// in_stall is high while the memory is cleared one row per cycle after reset.
// ----------------------------------------------------------------------------
module per_joint_motion_stats
  import pjms_pkg::*;
#(
  parameter int NUM_JOINTS = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [FRAME_W-1:0]  cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SLOT_W-1:0]   joint_slot,
  input  logic [FRAME_W-1:0]  frame_number,
  input  coord_t              pos_x,
  input  coord_t              pos_y,
  input  coord_t              pos_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                accepted,
  output coord_t              low_x,
  output coord_t              low_y,
  output coord_t              low_z,
  output coord_t              high_x,
  output coord_t              high_y,
  output coord_t              high_z,
  output sum_t                travel_x,
  output sum_t                travel_y,
  output sum_t                travel_z,
  output count_t              sample_count
);

  localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  // One bit above the wider of slot and address so NUM_JOINTS itself fits.
  localparam int SW = ((AW > SLOT_W) ? AW : SLOT_W) + 1;

  logic [FRAME_W-1:0] start_frame;

  joint_stats_t stats_mem [NUM_JOINTS];
  joint_stats_t rd_row;

  logic          clr_active;
  logic [AW-1:0] clr_addr;

  logic              s1_valid;
  logic              s1_apply;
  logic [AW-1:0]     s1_addr;
  coord_t [AXES-1:0] s1_pos;

  logic         wb_valid;
  logic [AW-1:0] wb_addr;
  joint_stats_t wb_row;

  logic          in_accept;
  logic          out_free;
  logic          out_load;
  logic          commit;
  logic [SW-1:0] slot_wide;
  logic          slot_ok;
  logic [AW-1:0] in_addr;

  joint_stats_t cur_row;
  joint_stats_t row_next;

  assign slot_wide = SW'(joint_slot);
  assign slot_ok   = slot_wide < SW'(NUM_JOINTS);
  assign in_addr   = slot_wide[AW-1:0];

  assign out_free  = !out_valid || !out_stall;
  assign out_load  = s1_valid && out_free;
  assign in_stall  = clr_active || (s1_valid && !out_free);
  assign in_accept = in_valid && !in_stall;
  assign commit    = out_load && s1_apply;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_frame <= START_FRAME_RESET;
    end else if (cfg_we) begin
      start_frame <= cfg_wdata;
    end
  end

  // Clearing pass over the statistics memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(NUM_JOINTS - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      stats_mem[clr_addr] <= '0;
    end else if (commit) begin
      stats_mem[s1_addr] <= row_next;
    end
    if (in_accept) begin
      rd_row <= stats_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_apply  <= slot_ok && (frame_number >= start_frame);
      s1_addr   <= in_addr;
      s1_pos[0] <= pos_x;
      s1_pos[1] <= pos_y;
      s1_pos[2] <= pos_z;
    end
  end

  // The write-back register always matches the memory row at wb_addr, so it
  // can stand in for a read that missed the write of the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (commit) begin
      wb_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      wb_addr <= s1_addr;
      wb_row  <= row_next;
    end
  end

  always_comb begin
    logic signed [COORD_W:0] diff;
    logic [COORD_W-1:0]      step;
    logic [SUM_W:0]          sum;
    cur_row  = (wb_valid && (wb_addr == s1_addr)) ? wb_row : rd_row;
    row_next = cur_row;
    for (int a = 0; a < AXES; a++) begin
      diff = {s1_pos[a][COORD_W-1], s1_pos[a]}
           - {cur_row.last[a][COORD_W-1], cur_row.last[a]};
      step = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
      sum  = {1'b0, cur_row.travel[a]} + (SUM_W + 1)'(step);
      if (cur_row.count == '0) begin
        // First sample of this joint seeds its bounds and last position.
        row_next.low[a]    = s1_pos[a];
        row_next.high[a]   = s1_pos[a];
        row_next.travel[a] = cur_row.travel[a];
      end else begin
        row_next.low[a]    = (s1_pos[a] < cur_row.low[a])  ? s1_pos[a] : cur_row.low[a];
        row_next.high[a]   = (s1_pos[a] > cur_row.high[a]) ? s1_pos[a] : cur_row.high[a];
        row_next.travel[a] = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
      end
      row_next.last[a] = s1_pos[a];
    end
    row_next.count = (cur_row.count == '1) ? cur_row.count : cur_row.count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accepted <= s1_apply;
      if (s1_apply) begin
        low_x        <= row_next.low[0];
        low_y        <= row_next.low[1];
        low_z        <= row_next.low[2];
        high_x       <= row_next.high[0];
        high_y       <= row_next.high[1];
        high_z       <= row_next.high[2];
        travel_x     <= row_next.travel[0];
        travel_y     <= row_next.travel[1];
        travel_z     <= row_next.travel[2];
        sample_count <= row_next.count;
      end else begin
        low_x        <= '0;
        low_y        <= '0;
        low_z        <= '0;
        high_x       <= '0;
        high_y       <= '0;
        high_z       <= '0;
        travel_x     <= '0;
        travel_y     <= '0;
        travel_z     <= '0;
        sample_count <= '0;
      end
    end
  end

endmodule
